// File: sv/gasc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasc_pkg
// Shared types and constants of the glyph atlas slot cache.
// ----------------------------------------------------------------------------
package gasc_pkg;

    localparam int REV_DEPTH  = 65536;
    localparam int REV_AW     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;

    localparam logic [11:0] POS_MAX = 12'hfff;

    localparam logic [7:0] TILE_WIDTH_RST  = 8'd8;
    localparam logic [7:0] TILE_HEIGHT_RST = 8'd16;
    localparam logic [3:0] TILE_GAP_RST    = 4'd0;
    localparam logic [3:0] SHIFT_RST       = 4'd10;
    localparam logic [3:0] SHIFT_MIN       = 4'd8;
    localparam logic [3:0] SHIFT_MAX       = 4'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_WIDTH   = 3'd0,
        CFG_TILE_HEIGHT  = 3'd1,
        CFG_TILE_GAP     = 3'd2,
        CFG_WIDTH_SHIFT  = 3'd3,
        CFG_HEIGHT_SHIFT = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_REVERSE = 2'd1,
        CMD_OOR     = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] code_point;
        logic [15:0] uv_query;
    } t_cmd;

    typedef struct packed {
        logic [7:0] tile_width;
        logic [7:0] tile_height;
        logic [3:0] tile_gap;
        logic [2:0] ws_off;
        logic [2:0] hs_off;
    } t_cfg;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_EXEC  = 2'd2
    } t_back_state;

endpackage

// File: sv/gasc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasc_if
// Handshake channels: request words, response words and config writes.
// ----------------------------------------------------------------------------
interface gasc_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] code_point;
    logic [15:0] uv_query;

    modport source (output valid, mode, code_point, uv_query, input ready);
    modport sink   (input valid, mode, code_point, uv_query, output ready);
endinterface

interface gasc_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] uv;
    logic [15:0] code_point_out;
    logic [11:0] tile_x;
    logic [11:0] tile_y;
    logic        newly_placed;
    logic        atlas_full;

    modport source (output valid, uv, code_point_out, tile_x, tile_y, newly_placed,
                    atlas_full, input ready);
    modport sink   (input valid, uv, code_point_out, tile_x, tile_y, newly_placed,
                    atlas_full, output ready);
endinterface

interface gasc_cfg_if import gasc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/gasc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gasc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/gasc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasc_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module gasc_queue import gasc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// File: sv/gasc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasc_front
// Config registers and request intake: classifies each word for the back.
// ----------------------------------------------------------------------------
module gasc_front import gasc_pkg::*; #(
    parameter int CODE_POINTS = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gasc_req_if.sink       i_req,
    gasc_cfg_if.sink       i_cfg,
    input  logic           i_q_full,
    input  logic           i_init_done,
    output logic           o_push,
    output t_cmd           o_cmd,
    output t_cfg           o_cfg
);

    logic [7:0] r_tile_width;
    logic [7:0] r_tile_height;
    logic [3:0] r_tile_gap;
    logic [3:0] r_width_shift;
    logic [3:0] r_height_shift;

    function automatic logic [2:0] shift_off(input logic [3:0] s);
        logic [2:0] off;
        priority if (s < SHIFT_MIN) begin
            off = 3'd0;
        end else if (s > SHIFT_MAX) begin
            off = 3'(SHIFT_MAX - SHIFT_MIN);
        end else begin
            off = 3'(s - SHIFT_MIN);
        end
        return off;
    endfunction

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width   <= TILE_WIDTH_RST;
            r_tile_height  <= TILE_HEIGHT_RST;
            r_tile_gap     <= TILE_GAP_RST;
            r_width_shift  <= SHIFT_RST;
            r_height_shift <= SHIFT_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_TILE_WIDTH:   r_tile_width   <= i_cfg.data;
                CFG_TILE_HEIGHT:  r_tile_height  <= i_cfg.data;
                CFG_TILE_GAP:     r_tile_gap     <= i_cfg.data[3:0];
                CFG_WIDTH_SHIFT:  r_width_shift  <= i_cfg.data[3:0];
                CFG_HEIGHT_SHIFT: r_height_shift <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.tile_width  = r_tile_width;
        o_cfg.tile_height = r_tile_height;
        o_cfg.tile_gap    = r_tile_gap;
        o_cfg.ws_off      = shift_off(r_width_shift);
        o_cfg.hs_off      = shift_off(r_height_shift);
    end

    assign i_req.ready = !i_q_full && i_init_done;
    assign o_push      = i_req.valid && i_req.ready;

    always_comb begin
        o_cmd.code_point = i_req.code_point;
        o_cmd.uv_query   = i_req.uv_query;
        priority if (i_req.mode) begin
            o_cmd.kind = CMD_REVERSE;
        end else if ({1'b0, i_req.code_point} >= 17'(CODE_POINTS)) begin
            o_cmd.kind = CMD_OOR;
        end else begin
            o_cmd.kind = CMD_LOOKUP;
        end
    end

endmodule

// File: sv/gasc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasc_back
// Table clearing sweep, lookup, reverse lookup and placement, and the response register.
// ----------------------------------------------------------------------------
module gasc_back import gasc_pkg::*; #(
    parameter int CODE_POINTS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    input  logic        i_q_empty,
    output logic        o_pop,
    output logic        o_init_done,
    gasc_rsp_if.source  o_rsp
);

    localparam int CP_AW = $clog2(CODE_POINTS);

    typedef struct packed {
        logic        room;
        logic        wrap;
        logic [15:0] uv;
        logic [11:0] adv_x;
        logic [11:0] adv_y;
    } t_plc;

    typedef struct packed {
        logic [15:0] uv;
        logic [15:0] code_point_out;
        logic [11:0] tile_x;
        logic [11:0] tile_y;
        logic        newly_placed;
        logic        atlas_full;
    } t_rsp;

    t_back_state       r_state, n_state;
    logic [REV_AW-1:0] r_clr_addr;
    t_cmd              r_cmd;
    t_plc              r_plc, n_plc;
    logic [11:0]       r_next_x;
    logic [11:0]       r_next_y;
    logic              r_out_valid;
    t_rsp              r_out, n_rsp;
    logic              load_out;
    logic              place;
    logic              out_free;

    logic             gt_we, gt_re;
    logic [CP_AW-1:0] gt_waddr, gt_raddr;
    logic [16:0]      gt_wdata, gt_rdata;
    logic              rv_we, rv_re;
    logic [REV_AW-1:0] rv_waddr, rv_raddr;
    logic [15:0]       rv_wdata, rv_rdata;

    logic [12:0] tex_w, tex_h;
    logic [13:0] lim_x, lim_y;
    logic [8:0]  cw, ch;
    logic [9:0]  a4w, a4h;
    logic [12:0] sx, sy;

    gasc_ram #(.WIDTH(17), .DEPTH(CODE_POINTS)) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (gt_we),
        .i_waddr (gt_waddr),
        .i_wdata (gt_wdata),
        .i_re    (gt_re),
        .i_raddr (gt_raddr),
        .o_rdata (gt_rdata)
    );

    gasc_ram #(.WIDTH(16), .DEPTH(REV_DEPTH)) u_rev_ram (
        .i_clk   (i_clk),
        .i_we    (rv_we),
        .i_waddr (rv_waddr),
        .i_wdata (rv_wdata),
        .i_re    (rv_re),
        .i_raddr (rv_raddr),
        .o_rdata (rv_rdata)
    );

    // placement candidate from the current running position
    always_comb begin
        tex_w = 13'd256 << i_cfg.ws_off;
        tex_h = 13'd256 << i_cfg.hs_off;
        cw    = 9'(i_cfg.tile_width) + 9'(i_cfg.tile_gap);
        ch    = 9'(i_cfg.tile_height) + 9'(i_cfg.tile_gap);
        a4w   = (10'(cw) + 10'd3) & ~10'd3;
        a4h   = (10'(ch) + 10'd3) & ~10'd3;
        lim_y = 14'(tex_h) - 14'(i_cfg.tile_height) - 14'(i_cfg.tile_gap);
        lim_x = 14'(tex_w) - 14'(cw) - 14'(i_cfg.tile_gap);
        sx    = 13'(r_next_x) + 13'(a4w);
        sy    = 13'(r_next_y) + 13'(a4h);

        n_plc.room  = $signed({2'b00, r_next_y}) < $signed(lim_y);
        n_plc.adv_x = (sx > 13'(POS_MAX)) ? POS_MAX : sx[11:0];
        n_plc.adv_y = (sy > 13'(POS_MAX)) ? POS_MAX : sy[11:0];
        n_plc.wrap  = $signed({2'b00, n_plc.adv_x}) >= $signed(lim_x);
        n_plc.uv    = {8'(r_next_y >> i_cfg.hs_off), 8'(r_next_x >> i_cfg.ws_off)};
    end

    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        place    = 1'b0;
        n_rsp    = '0;
        gt_re    = 1'b0;
        rv_re    = 1'b0;
        gt_raddr = i_cmd.code_point[CP_AW-1:0];
        rv_raddr = i_cmd.uv_query;
        gt_we    = 1'b0;
        rv_we    = 1'b0;
        gt_waddr = r_cmd.code_point[CP_AW-1:0];
        gt_wdata = {1'b1, r_plc.uv};
        rv_waddr = r_plc.uv;
        rv_wdata = r_cmd.code_point;

        unique case (r_state)
            BK_CLEAR: begin
                gt_we    = ({1'b0, r_clr_addr} < 17'(CODE_POINTS));
                rv_we    = 1'b1;
                gt_waddr = r_clr_addr[CP_AW-1:0];
                gt_wdata = '0;
                rv_waddr = r_clr_addr;
                rv_wdata = '0;
                if (r_clr_addr == REV_AW'(REV_DEPTH - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    gt_re   = (i_cmd.kind == CMD_LOOKUP);
                    rv_re   = (i_cmd.kind == CMD_REVERSE);
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                    unique case (r_cmd.kind)
                        CMD_REVERSE: begin
                            n_rsp.uv             = r_cmd.uv_query;
                            n_rsp.code_point_out = rv_rdata;
                        end
                        CMD_LOOKUP: begin
                            priority if (gt_rdata[16]) begin
                                n_rsp.uv     = gt_rdata[15:0];
                                n_rsp.tile_x = 12'({4'b0, gt_rdata[7:0]} << i_cfg.ws_off);
                                n_rsp.tile_y = 12'({4'b0, gt_rdata[15:8]} << i_cfg.hs_off);
                            end else if (r_plc.room) begin
                                place              = 1'b1;
                                n_rsp.uv           = r_plc.uv;
                                n_rsp.tile_x       = r_next_x;
                                n_rsp.tile_y       = r_next_y;
                                n_rsp.newly_placed = 1'b1;
                            end else begin
                                n_rsp.atlas_full = 1'b1;
                            end
                        end
                        CMD_OOR: ;
                        default: ;
                    endcase
                    gt_we = place;
                    rv_we = place;
                end
            end
            default: n_state = BK_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_next_x    <= '0;
            r_next_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (place) begin
                r_next_x <= r_plc.wrap ? '0 : r_plc.adv_x;
                r_next_y <= r_plc.wrap ? r_plc.adv_y : r_next_y;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_plc <= n_plc;
        end
        if (load_out) begin
            r_out <= n_rsp;
        end
    end

    assign o_init_done          = (r_state != BK_CLEAR);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.uv             = r_out.uv;
    assign o_rsp.code_point_out = r_out.code_point_out;
    assign o_rsp.tile_x         = r_out.tile_x;
    assign o_rsp.tile_y         = r_out.tile_y;
    assign o_rsp.newly_placed   = r_out.newly_placed;
    assign o_rsp.atlas_full     = r_out.atlas_full;

`ifndef SYNTHESIS
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CLEAR) |-> !o_pop)
        else $error("queue popped during table clear");

    a_pop_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == BK_EXEC))
        else $error("popped word not executed");

    a_place_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_EXEC && gt_we) |=> (r_out_valid && r_out.newly_placed))
        else $error("table write without placement response");

    a_full_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && n_rsp.atlas_full) |=> ($stable(r_next_x) && $stable(r_next_y)))
        else $error("position moved on full atlas");
`endif

endmodule

// File: sv/glyph_atlas_slot_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_atlas_slot_cache
// Glyph atlas cache: code point lookup with tile allocation, uv reverse map.
// ----------------------------------------------------------------------------
// a request word goes through the command queue, a table read in the back and the response register
// the back handles one word at a time: a glyph table read, then a write on placement
// two-entry command queue lets requests be taken while a response waits
// reset: both tables are cleared by a sweep over all 65536 addresses, requests held off
// config writes are taken at all times, including during the sweep
module glyph_atlas_slot_cache import gasc_pkg::*; #(
    parameter int CODE_POINTS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gasc_req_if.sink    i_req,
    gasc_cfg_if.sink    i_cfg,
    gasc_rsp_if.source  o_rsp
);

    logic q_push, q_pop, q_full, q_empty, init_done;
    t_cmd front_cmd, q_cmd;
    t_cfg cfg;

    gasc_front #(.CODE_POINTS(CODE_POINTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg       (i_cfg),
        .i_q_full    (q_full),
        .i_init_done (init_done),
        .o_push      (q_push),
        .o_cmd       (front_cmd),
        .o_cfg       (cfg)
    );

    gasc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    gasc_back #(.CODE_POINTS(CODE_POINTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (q_cmd),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_init_done (init_done),
        .o_rsp       (o_rsp)
    );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the glyph atlas slot cache. Lookup and reverse
// words go in with random gaps; a local model of the tile placer and both
// tables predicts every response word, which is checked in order as it
// arrives under random and long output back-pressure, across several atlas
// settings from the smallest textures and largest tiles to the largest
// textures.
// ----------------------------------------------------------------------------
module tb;
    import gasc_pkg::*;

    localparam int CODE_POINTS    = 65536;
    localparam int LATENCY        = 2;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_WORDS    = 240;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [15:0] uv;
        logic [15:0] code_point_out;
        logic [11:0] tile_x;
        logic [11:0] tile_y;
        logic        newly_placed;
        logic        atlas_full;
    } t_atlas_word;

    logic i_clk;
    logic i_rst_n;

    gasc_req_if req_if ();
    gasc_rsp_if rsp_if ();
    gasc_cfg_if cfg_if ();

    glyph_atlas_slot_cache #(
        .CODE_POINTS(CODE_POINTS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .i_cfg  (cfg_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // model of the atlas
    logic [7:0]  cfg_tile_w = TILE_WIDTH_RST;
    logic [7:0]  cfg_tile_h = TILE_HEIGHT_RST;
    logic [3:0]  cfg_gap    = TILE_GAP_RST;
    logic [3:0]  cfg_ws     = SHIFT_RST;
    logic [3:0]  cfg_hs     = SHIFT_RST;
    int          pos_x      = 0;
    int          pos_y      = 0;
    bit   [16:0] glyph_tbl [CODE_POINTS];
    bit   [15:0] rev_tbl   [65536];
    logic [15:0] placed_codes [$];

    t_atlas_word expected_tiles [$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          hold_request   = 0;
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int round_up4(input int v);
        return (v + 3) & ~3;
    endfunction

    function automatic int clip_pos(input int v);
        return (v > int'(POS_MAX)) ? int'(POS_MAX) : v;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 2);
        if (roll < 94) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_atlas_word predict_atlas_word(input logic mode, input logic [15:0] cp,
                                                       input logic [15:0] uq);
        t_atlas_word r;
        int          ws;
        int          hs;
        int          cw;
        int          nx;
        int          ny;
        logic [16:0] entry;
        logic [15:0] uv;
        r  = '0;
        ws = int'(cfg_ws);
        hs = int'(cfg_hs);
        if (ws < int'(SHIFT_MIN)) ws = int'(SHIFT_MIN);
        if (ws > int'(SHIFT_MAX)) ws = int'(SHIFT_MAX);
        if (hs < int'(SHIFT_MIN)) hs = int'(SHIFT_MIN);
        if (hs > int'(SHIFT_MAX)) hs = int'(SHIFT_MAX);
        if (mode) begin
            r.uv             = uq;
            r.code_point_out = rev_tbl[uq];
        end else if (int'(cp) < CODE_POINTS) begin
            entry = glyph_tbl[cp];
            if (entry[16]) begin
                r.uv     = entry[15:0];
                r.tile_x = 12'((int'(entry[7:0]) << (ws - 8)) & int'(POS_MAX));
                r.tile_y = 12'((int'(entry[15:8]) << (hs - 8)) & int'(POS_MAX));
            end else if (pos_y >= (1 << hs) - int'(cfg_tile_h) - int'(cfg_gap)) begin
                r.atlas_full = 1'b1;
            end else begin
                cw = int'(cfg_tile_w) + int'(cfg_gap);
                uv = {8'((pos_y >> (hs - 8)) & 'hff), 8'((pos_x >> (ws - 8)) & 'hff)};
                glyph_tbl[cp] = {1'b1, uv};
                rev_tbl[uv]   = cp;
                placed_codes.push_back(cp);
                r.uv           = uv;
                r.tile_x       = 12'(pos_x);
                r.tile_y       = 12'(pos_y);
                r.newly_placed = 1'b1;
                nx = clip_pos(pos_x + round_up4(cw));
                ny = pos_y;
                // row wrap
                if (nx >= (1 << ws) - cw - int'(cfg_gap)) begin
                    nx = 0;
                    ny = clip_pos(pos_y + round_up4(int'(cfg_tile_h) + int'(cfg_gap)));
                end
                pos_x = nx;
                pos_y = ny;
            end
        end
        return r;
    endfunction

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            CFG_TILE_WIDTH:   cfg_tile_w = data;
            CFG_TILE_HEIGHT:  cfg_tile_h = data;
            CFG_TILE_GAP:     cfg_gap    = data[3:0];
            CFG_WIDTH_SHIFT:  cfg_ws     = data[3:0];
            CFG_HEIGHT_SHIFT: cfg_hs     = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_atlas(input logic [7:0] tw, input logic [7:0] th, input logic [7:0] gap,
                             input logic [7:0] ws, input logic [7:0] hs);
        write_cfg(CFG_TILE_WIDTH, tw);
        write_cfg(CFG_TILE_HEIGHT, th);
        write_cfg(CFG_TILE_GAP, gap);
        write_cfg(CFG_WIDTH_SHIFT, ws);
        write_cfg(CFG_HEIGHT_SHIFT, hs);
    endtask

    task automatic send_atlas_word(input logic mode, input logic [15:0] cp,
                                   input logic [15:0] uq);
        int gap;
        gap = (sender_idles && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.mode       <= mode;
        req_if.code_point <= cp;
        req_if.uv_query   <= uq;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        expected_tiles.push_back(predict_atlas_word(mode, cp, uq));
    endtask

    task automatic send_random_word();
        int          roll;
        logic [15:0] cp;
        logic [15:0] uq;
        logic [15:0] pick;
        roll = $urandom_range(0, 99);
        cp   = 16'($urandom_range(0, 65535));
        uq   = 16'($urandom_range(0, 65535));
        pick = (placed_codes.size() != 0) ?
               placed_codes[$urandom_range(0, placed_codes.size() - 1)] : cp;
        if (roll < 20)      send_atlas_word(1'b0, cp, uq);
        else if (roll < 40) send_atlas_word(1'b0, 16'($urandom_range(0, 1023)), uq);
        else if (roll < 70) send_atlas_word(1'b0, pick, uq);
        else if (roll < 85) send_atlas_word(1'b1, cp, glyph_tbl[pick][15:0]);
        else                send_atlas_word(1'b1, cp, uq);
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_tiles.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic check_atlas_word();
        t_atlas_word got;
        t_atlas_word want;
        got.uv             = rsp_if.uv;
        got.code_point_out = rsp_if.code_point_out;
        got.tile_x         = rsp_if.tile_x;
        got.tile_y         = rsp_if.tile_y;
        got.newly_placed   = rsp_if.newly_placed;
        got.atlas_full     = rsp_if.atlas_full;
        if (expected_tiles.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected word: uv=%h cp=%h x=%0d y=%0d placed=%b full=%b",
                         got.uv, got.code_point_out, got.tile_x, got.tile_y,
                         got.newly_placed, got.atlas_full);
        end else begin
            want = expected_tiles.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("mismatch: exp uv=%h cp=%h x=%0d y=%0d placed=%b full=%b",
                             want.uv, want.code_point_out, want.tile_x, want.tile_y,
                             want.newly_placed, want.atlas_full);
                    $display("          got uv=%h cp=%h x=%0d y=%0d placed=%b full=%b",
                             got.uv, got.code_point_out, got.tile_x, got.tile_y,
                             got.newly_placed, got.atlas_full);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            check_atlas_word();
    end

    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // response side ready, with random stalls and requested long holds
    initial begin : rsp_sink
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (receiver_idles && $urandom_range(0, 99) < 25) begin
                stall_left   = pick_gap() - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    task automatic test_lookup_basics();
        send_atlas_word(1'b0, 16'h0000, 16'hffff);
        send_atlas_word(1'b0, 16'hffff, 16'h0000);
        send_atlas_word(1'b0, 16'h0000, 16'h0000);
        send_atlas_word(1'b0, 16'h8000, 16'h5555);
        send_atlas_word(1'b0, 16'h5555, 16'haaaa);
        send_atlas_word(1'b1, 16'hffff, glyph_tbl[16'hffff][15:0]);
        send_atlas_word(1'b1, 16'haaaa, 16'hffff);
        send_atlas_word(1'b1, 16'h0000, 16'h0000);
        wait_all_results();
    endtask

    // scaled coordinates collide, so the reverse map keeps the latest
    task automatic test_shared_uv();
        set_atlas(8'd4, 8'd1, 8'd0, 8'd12, 8'd12);
        send_atlas_word(1'b0, 16'h0100, 16'h0000);
        send_atlas_word(1'b0, 16'h0101, 16'h0000);
        send_atlas_word(1'b1, 16'h0000, glyph_tbl[16'h0101][15:0]);
        wait_all_results();
    endtask

    // zero pitch, shifts out of range, junk in upper data bits
    task automatic test_zero_tile();
        set_atlas(8'd0, 8'd0, 8'hf0, 8'h17, 8'hfd);
        write_cfg(CFG_UNUSED, 8'hff);
        send_atlas_word(1'b0, 16'h0200, 16'h0000);
        send_atlas_word(1'b0, 16'h0201, 16'h0000);
        send_atlas_word(1'b1, 16'h0000, glyph_tbl[16'h0201][15:0]);
        send_atlas_word(1'b0, 16'h0200, 16'h0000);
        wait_all_results();
    endtask

    task automatic test_wrap_and_full();
        set_atlas(8'd255, 8'd255, 8'd0, 8'd8, 8'd8);
        send_atlas_word(1'b0, 16'h0300, 16'h0000);
        send_atlas_word(1'b0, 16'h0301, 16'h0000);
        send_atlas_word(1'b0, 16'h0301, 16'h0000);
        send_atlas_word(1'b0, 16'h0300, 16'h0000);
        send_atlas_word(1'b0, 16'h0000, 16'h0000);
        wait_all_results();
    endtask

    task automatic phase_atlas(input int phase);
        logic [7:0] tw;
        logic [7:0] th;
        logic [7:0] gap;
        logic [7:0] ws;
        logic [7:0] hs;
        tw  = ($urandom_range(0, 9) == 0) ? 8'd0 :
              ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(1, 32));
        th  = ($urandom_range(0, 9) == 0) ? 8'd0 :
              ($urandom_range(0, 19) == 0) ? 8'd255 : 8'($urandom_range(1, 24));
        gap = 8'($urandom_range(0, 255));
        ws  = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
              8'($urandom_range(8, 12));
        hs  = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
              8'($urandom_range(11, 12));
        if (phase == 0) begin
            // widest tiles on the widest texture: the column saturates
            tw  = 8'd255;
            th  = 8'($urandom_range(1, 16));
            gap = 8'd0;
            ws  = 8'd12;
            hs  = 8'd12;
        end else if (phase == RANDOM_PHASES - 1) begin
            tw  = 8'd255;
            th  = 8'd255;
            gap = 8'h0f;
            ws  = 8'h00;
            hs  = 8'h0f;
        end
        set_atlas(tw, th, gap, ws, hs);
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            phase_atlas(phase);
            sender_idles   = (phase % 3) != 2;
            receiver_idles = (phase % 3) != 2 && phase != 4;
            repeat (PHASE_WORDS) send_random_word();
            wait_all_results();
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // output held off long enough to fill the block and stall its input
    task automatic test_output_backpressure();
        sender_idles = 1'b0;
        @(posedge i_clk);
        hold_request = LONG_HOLD;
        repeat (24) send_random_word();
        wait_all_results();
        repeat (6) send_random_word();
        wait_all_results();
        sender_idles = 1'b1;
    endtask

    initial begin : main
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.mode       = 1'b0;
        req_if.code_point = '0;
        req_if.uv_query   = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_TILE_WIDTH;
        cfg_if.data       = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_lookup_basics();
        test_shared_uv();
        test_zero_tile();
        test_wrap_and_full();
        test_random_traffic();
        test_output_backpressure();
        wait_all_results();

        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
